// ===== src/otc_pkg.sv =====
`timescale 1ns / 1ps

package otc_pkg;

  // Request kinds on the input channel
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_RESULT = 1'b1;

  // Phase field of a result
  localparam logic PHASE_COARSE = 1'b0;
  localparam logic PHASE_FINE   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COARSE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_FINE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_ENABLE  = 2'd3;

  typedef enum logic [1:0] {
    ACT_APPLY      = 2'd0,
    ACT_NEXT_PHASE = 2'd1,
    ACT_COMPLETE   = 2'd2,
    ACT_IGNORED    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OFF    = 2'd0,
    ST_COARSE = 2'd1,
    ST_FINE   = 2'd2,
    ST_DONE   = 2'd3
  } phase_state_e;

  typedef struct packed {
    phase_state_e st;
    logic         was_above;
    logic         was_below;
  } ctrl_t;

endpackage

// ===== src/otc_if.sv =====
`timescale 1ns / 1ps

interface otc_in_if #(
  parameter int COUNT_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [COUNT_WIDTH-1:0] measured_count;

  modport source (output valid, output func, output measured_count, input ready);
  modport sink   (input valid, input func, input measured_count, output ready);
endinterface

interface otc_out_if #(
  parameter int COARSE_WIDTH = 7
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic                    phase;
  logic [COARSE_WIDTH-1:0] trim_value;
  logic                    saturated;

  modport source (output valid, output action, output phase, output trim_value,
                  output saturated, input ready);
  modport sink   (input valid, input action, input phase, input trim_value,
                  input saturated, output ready);
endinterface

// ===== src/otc_step.sv =====
`timescale 1ns / 1ps

module otc_step #(
  parameter int COARSE_WIDTH = 7,
  parameter int FINE_WIDTH   = 6,
  parameter int COUNT_WIDTH  = 24,
  parameter int TRIM_W       = (COARSE_WIDTH > FINE_WIDTH) ? COARSE_WIDTH : FINE_WIDTH
) (
  input  logic                    func_i,
  input  logic [COUNT_WIDTH-1:0]  count_i,
  input  logic [COUNT_WIDTH-1:0]  target_i,
  input  logic [COARSE_WIDTH-1:0] init_coarse_i,
  input  logic [FINE_WIDTH-1:0]   init_fine_i,
  input  logic                    fine_en_i,
  input  otc_pkg::ctrl_t          ctrl_i,
  input  logic [TRIM_W-1:0]       cur_trim_i,
  input  logic [TRIM_W-1:0]       prev_trim_i,
  input  logic [COUNT_WIDTH-1:0]  prev_count_i,
  output otc_pkg::ctrl_t          ctrl_o,
  output logic [TRIM_W-1:0]       cur_trim_o,
  output logic [TRIM_W-1:0]       prev_trim_o,
  output logic [COUNT_WIDTH-1:0]  prev_count_o,
  output otc_pkg::action_e        action_o,
  output logic                    phase_o,
  output logic [COARSE_WIDTH-1:0] trim_o,
  output logic                    sat_o
);
  import otc_pkg::*;

  localparam logic [TRIM_W-1:0] COARSE_MAX = TRIM_W'({COARSE_WIDTH{1'b1}});
  localparam logic [TRIM_W-1:0] FINE_MAX   = TRIM_W'({FINE_WIDTH{1'b1}});
  localparam logic [COUNT_WIDTH-1:0] ONE   = COUNT_WIDTH'(1);

  logic                   active;
  logic                   fine_ph;
  logic                   below;
  logic [TRIM_W-1:0]      max_trim;
  logic [COUNT_WIDTH-1:0] err_lo;
  logic [COUNT_WIDTH-1:0] err_hi;
  logic [COUNT_WIDTH-1:0] prev_err_hi;
  logic [COUNT_WIDTH-1:0] prev_err_lo;
  logic                   finish;
  logic                   keep_prev;
  logic                   clamp;
  logic [TRIM_W-1:0]      next_trim;
  logic [TRIM_W-1:0]      final_trim;
  logic                   go_fine;

  // Compare and step decision
  always_comb begin
    active      = (ctrl_i.st == ST_COARSE) || (ctrl_i.st == ST_FINE);
    fine_ph     = (ctrl_i.st == ST_FINE);
    max_trim    = fine_ph ? FINE_MAX : COARSE_MAX;
    below       = count_i < target_i;
    err_lo      = target_i - count_i;
    err_hi      = count_i - target_i;
    prev_err_hi = prev_count_i - target_i;
    prev_err_lo = target_i - prev_count_i;
    finish      = 1'b0;
    keep_prev   = 1'b0;
    clamp       = 1'b0;
    next_trim   = cur_trim_i;
    if (count_i == target_i) begin
      finish = 1'b1;
    end else if (below) begin
      if (ctrl_i.was_above) begin
        // crossed the target: keep the previous trim only if it landed strictly closer
        finish    = 1'b1;
        keep_prev = err_lo > prev_err_hi;
      end else if (err_lo == ONE) begin
        finish = 1'b1;
      end else if (cur_trim_i == '0) begin
        clamp = 1'b1;
      end else begin
        next_trim = cur_trim_i - TRIM_W'(1);
      end
    end else begin
      if (ctrl_i.was_below) begin
        finish    = 1'b1;
        keep_prev = err_hi > prev_err_lo;
      end else if (err_hi == ONE) begin
        finish = 1'b1;
      end else if (cur_trim_i >= max_trim) begin
        clamp = 1'b1;
      end else begin
        next_trim = cur_trim_i + TRIM_W'(1);
      end
    end
    final_trim = keep_prev ? prev_trim_i : cur_trim_i;
    go_fine    = !fine_ph && fine_en_i;
  end

  // Next state
  always_comb begin
    ctrl_o       = ctrl_i;
    cur_trim_o   = cur_trim_i;
    prev_trim_o  = prev_trim_i;
    prev_count_o = prev_count_i;
    if (func_i == FUNC_START) begin
      ctrl_o       = '{st: ST_COARSE, was_above: 1'b0, was_below: 1'b0};
      cur_trim_o   = TRIM_W'(init_coarse_i);
      prev_trim_o  = TRIM_W'(init_coarse_i);
      prev_count_o = '0;
    end else if (active) begin
      if (!finish) begin
        prev_trim_o  = cur_trim_i;
        prev_count_o = count_i;
        cur_trim_o   = next_trim;
        if (below) begin
          ctrl_o.was_below = 1'b1;
        end else begin
          ctrl_o.was_above = 1'b1;
        end
      end else if (go_fine) begin
        ctrl_o       = '{st: ST_FINE, was_above: 1'b0, was_below: 1'b0};
        cur_trim_o   = TRIM_W'(init_fine_i);
        prev_trim_o  = TRIM_W'(init_fine_i);
        prev_count_o = '0;
      end else begin
        cur_trim_o = final_trim;
        ctrl_o.st  = ST_DONE;
      end
    end
  end

  // Result
  always_comb begin
    action_o = ACT_IGNORED;
    phase_o  = PHASE_COARSE;
    trim_o   = '0;
    sat_o    = 1'b0;
    if (func_i == FUNC_START) begin
      action_o = ACT_APPLY;
      trim_o   = init_coarse_i;
    end else if (active) begin
      phase_o = fine_ph ? PHASE_FINE : PHASE_COARSE;
      if (!finish) begin
        action_o = ACT_APPLY;
        trim_o   = next_trim[COARSE_WIDTH-1:0];
        sat_o    = clamp;
      end else begin
        action_o = go_fine ? ACT_NEXT_PHASE : ACT_COMPLETE;
        trim_o   = final_trim[COARSE_WIDTH-1:0];
      end
    end
  end

endmodule

// ===== src/oscillator_trim_calibrator_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// in_i      sink       func, measured_count
// out_o     source     action, phase, trim_value, saturated
// cfg_*     write      cfg_idx_i selects the register, cfg_wdata_i carries the value
//
// One request per cycle while the output accepts results; each request gives
// exactly one result, held in the input register and then in the result register.
// The compare and step logic sits between those registers and updates the state there.
// Reset clears the phase state and restores the register defaults.
// A stalled output holds its result; the input register still fills behind it.

module oscillator_trim_calibrator_unit #(
  parameter int COARSE_WIDTH = 7,
  parameter int FINE_WIDTH   = 6,
  parameter int COUNT_WIDTH  = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  otc_in_if.sink                               in_i,
  otc_out_if.source                            out_o,
  input  logic                                 cfg_we_i,
  input  logic [otc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [COUNT_WIDTH-1:0]               cfg_wdata_i
);
  import otc_pkg::*;

  localparam int TRIM_W = (COARSE_WIDTH > FINE_WIDTH) ? COARSE_WIDTH : FINE_WIDTH;
  localparam logic [COUNT_WIDTH-1:0]  TARGET_RST = COUNT_WIDTH'(537731);
  localparam logic [COARSE_WIDTH-1:0] COARSE_RST = COARSE_WIDTH'(64);
  localparam logic [FINE_WIDTH-1:0]   FINE_RST   = FINE_WIDTH'(32);

  // Configuration
  logic [COUNT_WIDTH-1:0]  target_q;
  logic [COARSE_WIDTH-1:0] init_coarse_q;
  logic [FINE_WIDTH-1:0]   init_fine_q;
  logic                    fine_en_q;

  // Calibration state
  ctrl_t                  ctrl_q, ctrl_d;
  logic [TRIM_W-1:0]      cur_trim_q, cur_trim_d;
  logic [TRIM_W-1:0]      prev_trim_q, prev_trim_d;
  logic [COUNT_WIDTH-1:0] prev_count_q, prev_count_d;

  // Input register
  logic                   in_v_q;
  logic                   func_q;
  logic [COUNT_WIDTH-1:0] count_q;

  // Result register
  logic                    out_v_q;
  action_e                 action_q, action_d;
  logic                    phase_q, phase_d;
  logic [COARSE_WIDTH-1:0] trim_q, trim_d;
  logic                    sat_q, sat_d;

  logic advance;
  logic in_ready;

  assign advance  = !out_v_q || out_o.ready;
  assign in_ready = !in_v_q || advance;

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_v_q;
  assign out_o.action     = action_q;
  assign out_o.phase      = phase_q;
  assign out_o.trim_value = trim_q;
  assign out_o.saturated  = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= TARGET_RST;
      init_coarse_q <= COARSE_RST;
      init_fine_q   <= FINE_RST;
      fine_en_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_COUNT: target_q      <= cfg_wdata_i;
        REG_INIT_COARSE:  init_coarse_q <= cfg_wdata_i[COARSE_WIDTH-1:0];
        REG_INIT_FINE:    init_fine_q   <= cfg_wdata_i[FINE_WIDTH-1:0];
        REG_FINE_ENABLE:  fine_en_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  otc_step #(
    .COARSE_WIDTH (COARSE_WIDTH),
    .FINE_WIDTH   (FINE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .TRIM_W       (TRIM_W)
  ) u_step (
    .func_i       (func_q),
    .count_i      (count_q),
    .target_i     (target_q),
    .init_coarse_i(init_coarse_q),
    .init_fine_i  (init_fine_q),
    .fine_en_i    (fine_en_q),
    .ctrl_i       (ctrl_q),
    .cur_trim_i   (cur_trim_q),
    .prev_trim_i  (prev_trim_q),
    .prev_count_i (prev_count_q),
    .ctrl_o       (ctrl_d),
    .cur_trim_o   (cur_trim_d),
    .prev_trim_o  (prev_trim_d),
    .prev_count_o (prev_count_d),
    .action_o     (action_d),
    .phase_o      (phase_d),
    .trim_o       (trim_d),
    .sat_o        (sat_d)
  );

  // Control: valid flags and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      ctrl_q       <= '{st: ST_OFF, was_above: 1'b0, was_below: 1'b0};
      cur_trim_q   <= '0;
      prev_trim_q  <= '0;
      prev_count_q <= '0;
    end else begin
      if (in_ready) begin
        in_v_q <= in_i.valid;
      end
      if (advance) begin
        out_v_q <= in_v_q;
        // advance the state only when a request leaves the input register
        if (in_v_q) begin
          ctrl_q       <= ctrl_d;
          cur_trim_q   <= cur_trim_d;
          prev_trim_q  <= prev_trim_d;
          prev_count_q <= prev_count_d;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      func_q  <= in_i.func;
      count_q <= in_i.measured_count;
    end
    if (advance && in_v_q) begin
      action_q <= action_d;
      phase_q  <= phase_d;
      trim_q   <= trim_d;
      sat_q    <= sat_d;
    end
  end

endmodule

// ===== sim/tb_oscillator_trim_calibrator_unit.sv =====
`timescale 1ns / 1ps

module tb_oscillator_trim_calibrator_unit;
  import otc_pkg::*;

  localparam int CW = 7;
  localparam int FW = 6;
  localparam int NW = 24;
  localparam logic [CW-1:0] COARSE_MAX = 7'd127;
  localparam logic [CW-1:0] FINE_MAX = 7'd63;
  localparam logic [NW-1:0] COUNT_MAX = 24'hFFFFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT = 400;
  localparam int HOLD_LEN = 80;

  typedef struct {
    logic          func;
    logic [NW-1:0] count;
  } cal_req_t;

  typedef struct {
    action_e       act;
    logic          ph;
    logic [CW-1:0] trim;
    logic          sat;
  } trim_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [NW-1:0] cfg_wdata_i;

  otc_in_if #(.COUNT_WIDTH(NW)) in_if ();
  otc_out_if #(.COARSE_WIDTH(CW)) out_if ();

  oscillator_trim_calibrator_unit #(
    .COARSE_WIDTH(CW),
    .FINE_WIDTH(FW),
    .COUNT_WIDTH(NW)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if),
    .out_o(out_if),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the calibrator settings and search state
  logic [NW-1:0] cfg_target = 24'd537731;
  logic [CW-1:0] cfg_init_coarse = 7'd64;
  logic [FW-1:0] cfg_init_fine = 6'd32;
  logic cfg_fine_en = 1'b1;

  phase_state_e trim_state = ST_OFF;
  logic [CW-1:0] cur_trim = '0;
  logic [CW-1:0] prev_trim = '0;
  logic [NW-1:0] prev_count = '0;
  logic was_above = 1'b0;
  logic was_below = 1'b0;

  cal_req_t request_q[$];
  trim_resp_t trim_expect_q[$];

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int start_cnt = 0;
  int act_cnt[4] = '{0, 0, 0, 0};
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  task automatic enter_phase(input phase_state_e st, input logic [CW-1:0] trim);
    trim_state = st;
    cur_trim = trim;
    prev_trim = trim;
    prev_count = '0;
    was_above = 1'b0;
    was_below = 1'b0;
  endtask

  // Work out the response to one accepted request and queue it
  task automatic calc_trim_response(input logic f, input logic [NW-1:0] m);
    trim_resp_t r;
    logic [31:0] t32, m32, p32;
    logic [CW-1:0] nxt, fin, maxv;
    logic ph, fin_now, sat;
    t32 = {8'd0, cfg_target};
    m32 = {8'd0, m};
    p32 = {8'd0, prev_count};
    r = '{ACT_IGNORED, PHASE_COARSE, '0, 1'b0};
    fin_now = 1'b0;
    sat = 1'b0;
    if (f == FUNC_START) begin
      enter_phase(ST_COARSE, cfg_init_coarse);
      r = '{ACT_APPLY, PHASE_COARSE, cfg_init_coarse, 1'b0};
    end else if (trim_state == ST_COARSE || trim_state == ST_FINE) begin
      ph = (trim_state == ST_FINE) ? PHASE_FINE : PHASE_COARSE;
      maxv = (ph == PHASE_FINE) ? FINE_MAX : COARSE_MAX;
      fin = cur_trim;
      nxt = cur_trim;
      if (m32 == t32) begin
        fin_now = 1'b1;
      end else if (m32 < t32) begin
        if (was_above) begin
          fin_now = 1'b1;
          // crossing: keep the older trim only if it was strictly closer
          if ((t32 - m32) > (p32 - t32)) fin = prev_trim;
        end else if (t32 - m32 == 32'd1) begin
          fin_now = 1'b1;
        end else begin
          if (cur_trim == '0) sat = 1'b1;
          else nxt = cur_trim - 1'b1;
          was_below = 1'b1;
        end
      end else begin
        if (was_below) begin
          fin_now = 1'b1;
          if ((m32 - t32) > (t32 - p32)) fin = prev_trim;
        end else if (m32 - t32 == 32'd1) begin
          fin_now = 1'b1;
        end else begin
          if (cur_trim >= maxv) sat = 1'b1;
          else nxt = cur_trim + 1'b1;
          was_above = 1'b1;
        end
      end
      if (!fin_now) begin
        prev_trim = cur_trim;
        prev_count = m;
        cur_trim = nxt;
        r = '{ACT_APPLY, ph, nxt, sat};
      end else if (ph == PHASE_COARSE && cfg_fine_en) begin
        r = '{ACT_NEXT_PHASE, PHASE_COARSE, fin, 1'b0};
        enter_phase(ST_FINE, {1'b0, cfg_init_fine});
      end else begin
        cur_trim = fin;
        trim_state = ST_DONE;
        r = '{ACT_COMPLETE, ph, fin, 1'b0};
      end
    end
    trim_expect_q.push_back(r);
  endtask

  // Driver: offer queued requests, predict on acceptance
  always @(posedge clk_i) begin
    cal_req_t nxt_req;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        calc_trim_response(in_if.func, in_if.measured_count);
        accepted_cnt++;
        if (in_if.func == FUNC_START) start_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          nxt_req = request_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.func <= nxt_req.func;
          in_if.measured_count <= nxt_req.count;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction
  always @(posedge clk_i) begin
    trim_resp_t exp_r;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        act_cnt[out_if.action]++;
        if (trim_expect_q.size() == 0) begin
          $display("%0t: result with no request pending, action %0d trim %0d", $time,
                   out_if.action, out_if.trim_value);
          err_cnt++;
        end else begin
          exp_r = trim_expect_q.pop_front();
          if (out_if.action !== exp_r.act) begin
            $display("%0t: action expected %0d actual %0d", $time, exp_r.act, out_if.action);
            err_cnt++;
          end
          if (out_if.phase !== exp_r.ph) begin
            $display("%0t: phase expected %0d actual %0d", $time, exp_r.ph, out_if.phase);
            err_cnt++;
          end
          if (out_if.trim_value !== exp_r.trim) begin
            $display("%0t: trim expected %0d actual %0d", $time, exp_r.trim,
                     out_if.trim_value);
            err_cnt++;
          end
          if (out_if.saturated !== exp_r.sat) begin
            $display("%0t: saturated expected %0d actual %0d", $time, exp_r.sat,
                     out_if.saturated);
            err_cnt++;
          end
        end
      end
      // hold off once for a long stretch so the block backs up into its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               trim_expect_q.size());
      $display("tb_oscillator_trim_calibrator_unit failed");
      $finish;
    end
  end

  task automatic push_req(input logic f, input logic [NW-1:0] m);
    request_q.push_back('{f, m});
    queued_cnt++;
  endtask

  task automatic drain_all();
    while (accepted_cnt != queued_cnt || trim_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [NW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic write_settings(input logic [NW-1:0] t, input logic [CW-1:0] c,
                                input logic [FW-1:0] fi, input logic en);
    cfg_put(REG_TARGET_COUNT, t);
    cfg_put(REG_INIT_COARSE, {{(NW-CW){1'b0}}, c});
    cfg_put(REG_INIT_FINE, {{(NW-FW){1'b0}}, fi});
    cfg_put(REG_FINE_ENABLE, {{(NW-1){1'b0}}, en});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_target = t;
    cfg_init_coarse = c;
    cfg_init_fine = fi;
    cfg_fine_en = en;
  endtask

  function automatic int pick_slope();
    case ($urandom_range(3))
      0: return $urandom_range(1, 3);
      1: return $urandom_range(4, 300);
      2: return $urandom_range(300, 20000);
      default: return $urandom_range(20000, 200000);
    endcase
  endfunction

  // One calibration run against a crude oscillator: count falls as trim rises
  task automatic gen_sweep();
    int ideal, k, gtrim, gmax, mval, sgn, last_sgn, n;
    bit fine_g, done;
    push_req(FUNC_START, NW'($urandom));
    gtrim = int'(cfg_init_coarse);
    gmax = int'(COARSE_MAX);
    fine_g = 1'b0;
    ideal = int'($urandom_range(0, 140)) - 6;
    k = pick_slope();
    last_sgn = 0;
    done = 1'b0;
    n = $urandom_range(1, 40);
    for (int i = 0; i < n && !done; i++) begin
      if ($urandom_range(99) < 3) begin
        // restart mid-run
        push_req(FUNC_START, NW'($urandom));
        gtrim = int'(cfg_init_coarse);
        gmax = int'(COARSE_MAX);
        fine_g = 1'b0;
        last_sgn = 0;
      end else begin
        mval = int'(cfg_target) + k * (ideal - gtrim) + int'($urandom_range(0, 4)) - 2;
        if (mval < 0) mval = 0;
        if (mval > int'(COUNT_MAX)) mval = int'(COUNT_MAX);
        push_req(FUNC_RESULT, NW'(mval));
        sgn = (mval > int'(cfg_target)) ? 1 : (mval < int'(cfg_target)) ? -1 : 0;
        if (sgn == 0 || mval - int'(cfg_target) == 1 || int'(cfg_target) - mval == 1 ||
            (last_sgn != 0 && sgn != last_sgn)) begin
          if (!fine_g && cfg_fine_en) begin
            fine_g = 1'b1;
            gtrim = int'(cfg_init_fine);
            gmax = int'(FINE_MAX);
            ideal = int'($urandom_range(0, 70)) - 3;
            k = pick_slope();
            last_sgn = 0;
          end else begin
            done = 1'b1;
          end
        end else begin
          gtrim = gtrim + sgn;
          if (gtrim < 0) gtrim = 0;
          if (gtrim > gmax) gtrim = gmax;
          last_sgn = sgn;
        end
      end
    end
    // stray measurements after the run
    repeat ($urandom_range(0, 2)) push_req(FUNC_RESULT, NW'($urandom));
  endtask

  initial begin
    logic [NW-1:0] tc;
    int base;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.func = FUNC_START;
    in_if.measured_count = '0;
    out_if.ready = 1'b0;
    snd_idle_pct = 18;
    rcv_idle_pct = 45;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, results while off and done, steps, crossings, tie
    tc = cfg_target;
    push_req(FUNC_RESULT, '0);
    push_req(FUNC_RESULT, COUNT_MAX);
    push_req(FUNC_START, '0);
    push_req(FUNC_RESULT, tc + NW'(1000));
    push_req(FUNC_RESULT, tc + NW'(500));
    push_req(FUNC_RESULT, tc - NW'(200));
    push_req(FUNC_RESULT, tc - NW'(300));
    push_req(FUNC_RESULT, tc + NW'(900));
    push_req(FUNC_RESULT, tc);
    push_req(FUNC_START, COUNT_MAX);
    push_req(FUNC_RESULT, tc);
    push_req(FUNC_RESULT, tc + NW'(1));
    push_req(FUNC_START, '0);
    push_req(FUNC_RESULT, tc - NW'(1));
    push_req(FUNC_RESULT, tc - NW'(1));
    push_req(FUNC_START, '0);
    push_req(FUNC_RESULT, tc + NW'(100));
    push_req(FUNC_RESULT, tc - NW'(100));
    push_req(FUNC_RESULT, tc + NW'(100));
    drain_all();

    // Directed: saturation at the low end of the coarse trim and the high end of the fine trim
    write_settings(tc, '0, 6'd63, 1'b1);
    push_req(FUNC_START, '0);
    push_req(FUNC_RESULT, '0);
    push_req(FUNC_RESULT, '0);
    push_req(FUNC_RESULT, tc + NW'(5));
    push_req(FUNC_RESULT, COUNT_MAX);
    push_req(FUNC_RESULT, COUNT_MAX);
    push_req(FUNC_RESULT, '0);
    drain_all();

    for (int p = 2; p < 8; p++) begin
      case (p)
        2: write_settings(NW'($urandom_range(1000, 24'hFFFFF)), CW'($urandom),
                          FW'($urandom), 1'b1);
        3: write_settings('0, COARSE_MAX, '0, 1'b0);
        4: write_settings(COUNT_MAX, COARSE_MAX, 6'd63, 1'b1);
        5: write_settings(NW'($urandom), '0, '0, 1'b1);
        6: write_settings(NW'($urandom_range(0, 24'hFFFFF)), CW'($urandom),
                          FW'($urandom), 1'($urandom));
        default: write_settings(24'd537731, 7'd64, 6'd32, 1'b0);
      endcase
      if (p >= 6) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end else if (p >= 3) begin
        snd_idle_pct = 45;
        rcv_idle_pct = 18;
      end
      base = queued_cnt;
      while (queued_cnt - base < 250) begin
        if ($urandom_range(99) < 10) begin
          repeat ($urandom_range(1, 6)) push_req(1'($urandom), NW'($urandom));
        end else begin
          gen_sweep();
        end
      end
      drain_all();
    end

    repeat (10) @(posedge clk_i);
    $display("Ran %0d requests (%0d starts) over eight settings, incl. register extremes.",
             accepted_cnt, start_cnt);
    $display("Results: %0d apply, %0d next phase, %0d complete, %0d ignored.",
             act_cnt[ACT_APPLY], act_cnt[ACT_NEXT_PHASE], act_cnt[ACT_COMPLETE],
             act_cnt[ACT_IGNORED]);
    if (err_cnt == 0 && trim_expect_q.size() == 0) begin
      $display("tb_oscillator_trim_calibrator_unit passed");
    end else begin
      $display("tb_oscillator_trim_calibrator_unit failed");
    end
    $finish;
  end

endmodule
